/* hw/rtl/tt_pkg.sv */
// Shared types and constants of the timeout table.
// Holds the command and status codes and the controller/datapath interface structs.
// Used by every module of the block; depends on nothing else.
package tt_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int NUM_TIMERS_DEF = 16;
	localparam int TIME_BITS_DEF  = 32;

	// Fixed field widths of the stream items.
	localparam int CMD_W    = 2;
	localparam int NOW_W    = 32;
	localparam int HANDLE_W = 16;
	localparam int STATUS_W = 3;

	// Input command codes.
	localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_FIRED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture the accepted item
		logic add;    // store a new timer at the end of the table
		logic step;   // take the head entry, keep or drop it
		logic flush;  // move the held result to the output register as the last one
	} tt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic tick;       // the held item is a tick
		logic scan_done;  // every entry of the run has been visited
		logic step_ok;    // a step can be taken without losing a result
		logic out_free;   // the output register can take a result
		logic pend_v;     // a result is held back awaiting its last mark
	} tt_stat_t;

endpackage

/* hw/rtl/tt_datapath.sv */
// Datapath of the timeout table: the packed timer table, the item registers,
// the held-back result and the output register. Depends on tt_pkg.
module tt_datapath import tt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tt_cmd_t             ctl,
	output tt_stat_t            stat,
	input  logic [CMD_W-1:0]    item_cmd,
	input  logic [NOW_W-1:0]    now_ms,
	input  logic [NOW_W-1:0]    delay_ms,
	input  logic                one_shot,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [HANDLE_W-1:0] out_handle,
	output logic                out_last
);

	localparam int CNT_W = $clog2(NUM_TIMERS + 1);

	// Timer table, kept packed at the low slots in insertion order.
	logic [HANDLE_W-1:0]  hdl_q   [NUM_TIMERS];
	logic [TIME_BITS-1:0] start_q [NUM_TIMERS];
	logic [TIME_BITS-1:0] dly_q   [NUM_TIMERS];
	logic                 shot_q  [NUM_TIMERS];
	logic [CNT_W-1:0]     cnt_q;
	logic [HANDLE_W-1:0]  next_hdl_q;

	// Registers of the item being worked on.
	logic [CMD_W-1:0]     cmd_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] new_dly_q;
	logic                 new_shot_q;
	logic [HANDLE_W-1:0]  hin_q;
	logic [CNT_W-1:0]     rem_q;

	// Result held back until it is known whether another one follows.
	logic                 pend_v_q;
	logic [STATUS_W-1:0]  pend_st_q;
	logic [HANDLE_W-1:0]  pend_hdl_q;

	logic [TIME_BITS-1:0] elapsed;
	logic                 fire;
	logic                 hit;
	logic                 emit;
	logic                 keep;
	logic                 full;
	logic                 out_free;

	// Decision on the head entry of the table.
	always_comb begin
		elapsed  = now_q - start_q[0];
		fire     = (cmd_q == CMD_TICK) && (elapsed > dly_q[0]);
		hit      = (cmd_q == CMD_REMOVE) && (hdl_q[0] == hin_q) && !pend_v_q;
		emit     = fire || hit;
		keep     = !(fire && shot_q[0]) && !hit;
		full     = (cnt_q == CNT_W'(NUM_TIMERS));
		out_free = !out_valid || out_ready;
	end

	// Status towards the controller.
	always_comb begin
		stat.tick      = (cmd_q == CMD_TICK);
		stat.scan_done = (rem_q == '0);
		stat.step_ok   = !(emit && pend_v_q) || out_free;
		stat.out_free  = out_free;
		stat.pend_v    = pend_v_q;
	end

	// Table entries: a step shifts every entry down by one and puts the kept
	// head back at the end; an add writes the first free slot.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_TIMERS; k++) begin
			if (ctl.step) begin
				if (k + 1 < int'(cnt_q)) begin
					hdl_q[k]   <= hdl_q[k + 1];
					start_q[k] <= start_q[k + 1];
					dly_q[k]   <= dly_q[k + 1];
					shot_q[k]  <= shot_q[k + 1];
				end
				if (keep && (k + 1 == int'(cnt_q))) begin
					hdl_q[k]   <= hdl_q[0];
					start_q[k] <= fire ? now_q : start_q[0];
					dly_q[k]   <= dly_q[0];
					shot_q[k]  <= shot_q[0];
				end
			end else if (ctl.add && !full && (k == int'(cnt_q))) begin
				hdl_q[k]   <= next_hdl_q;
				start_q[k] <= now_q;
				dly_q[k]   <= new_dly_q;
				shot_q[k]  <= new_shot_q;
			end
		end
	end

	// Item registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= item_cmd;
			now_q      <= TIME_BITS'(now_ms);
			new_dly_q  <= TIME_BITS'(delay_ms);
			new_shot_q <= one_shot;
			hin_q      <= handle_in;
		end
	end

	// Fill count, handle counter and the count of entries left to visit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			next_hdl_q <= '0;
			rem_q      <= '0;
		end else begin
			if (ctl.load) begin
				rem_q <= cnt_q;
			end
			if (ctl.step) begin
				rem_q <= rem_q - 1'b1;
				if (!keep) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (ctl.add && !full) begin
				cnt_q      <= cnt_q + 1'b1;
				next_hdl_q <= next_hdl_q + 1'b1;
			end
		end
	end

	// Held result and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ctl.step && emit) begin
				pend_v_q <= 1'b1;
			end
			if (ctl.add) begin
				pend_v_q <= 1'b1;
			end
			if (ctl.flush) begin
				pend_v_q <= 1'b0;
			end
			// A new result enters the output register, or the held one leaves it.
			if (ctl.flush || (ctl.step && emit && pend_v_q)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Payload of the held result and of the output register.
	always_ff @(posedge clk) begin
		if (ctl.step && emit) begin
			pend_st_q  <= fire ? ST_FIRED : ST_REMOVED;
			pend_hdl_q <= hdl_q[0];
			if (pend_v_q) begin
				out_status <= pend_st_q;
				out_handle <= pend_hdl_q;
				out_last   <= 1'b0;
			end
		end
		if (ctl.add) begin
			pend_st_q  <= full ? ST_FULL : ST_ADDED;
			pend_hdl_q <= full ? '0 : next_hdl_q;
		end
		if (ctl.flush) begin
			out_status <= pend_v_q ? pend_st_q : ST_NOTFOUND;
			out_handle <= pend_v_q ? pend_hdl_q : hin_q;
			out_last   <= 1'b1;
		end
	end

endmodule

/* hw/rtl/tt_ctrl.sv */
// Controller of the timeout table: sequences add, scan and flush per item.
// Drives tt_datapath through tt_cmd_t and reads tt_stat_t. Depends on tt_pkg.
module tt_ctrl import tt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] in_cmd,
	input  tt_stat_t         stat,
	output tt_cmd_t          ctl
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ADD   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		in_ready  = (state_q == S_IDLE);
		ctl       = '0;
		case (state_q)
			S_IDLE: begin
				ctl.load = in_valid;
				if (in_valid) begin
					if (in_cmd == CMD_ADD) begin
						state_d = S_ADD;
					end else if (in_cmd == CMD_TICK || in_cmd == CMD_REMOVE) begin
						state_d = S_SCAN;
					end
				end
			end
			S_ADD: begin
				ctl.add = 1'b1;
				state_d = S_FLUSH;
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					state_d = S_FLUSH;
				end else if (stat.step_ok) begin
					ctl.step = 1'b1;
				end
			end
			S_FLUSH: begin
				if (stat.tick && !stat.pend_v) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					ctl.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/timeout_table.sv */
// Top level of the timeout table: stream ports, controller and datapath.
// Instantiates tt_ctrl and tt_datapath; depends on tt_pkg.
//
// An ordered table of up to NUM_TIMERS timers. An add item stores a timer
// started at now_ms and returns a fresh wrapping 16-bit handle (or table full),
// a remove item deletes the first timer with the given handle (or reports it
// not found), and a tick item fires, in insertion order, every timer whose
// wrapping elapsed time exceeds its delay; fired one-shot timers go, periodic
// ones restart at now_ms. The block takes one item at a time. The scan of a
// tick or a remove visits one table entry per cycle by shifting the table
// through its head; a full output register stalls the scan. Results leave
// through a registered output stage, with tlast on the last result of each
// item; a tick with nothing due and the unused command code give no result.
module timeout_table import tt_pkg::*; #(
	parameter int NUM_TIMERS = NUM_TIMERS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // now_ms[31:0], delay_ms[63:32], one_shot[64],
	                               // handle_in[80:65], zeros[87:81]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // handle_out[15:0]
	output logic [2:0]  m_tuser,   // status[2:0]
	output logic        m_tlast
);

	tt_cmd_t  ctl;
	tt_stat_t stat;

	// Sequencing of each item.
	tt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Timer table and result path.
	tt_datapath #(
		.NUM_TIMERS (NUM_TIMERS),
		.TIME_BITS  (TIME_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.item_cmd   (s_tuser),
		.now_ms     (s_tdata[31:0]),
		.delay_ms   (s_tdata[63:32]),
		.one_shot   (s_tdata[64]),
		.handle_in  (s_tdata[80:65]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_handle (m_tdata),
		.out_last   (m_tlast)
	);

	// No result is held back while the block waits for a new item.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.pend_v)
		else $error("result still held back while idle");

	// Only a tick gives more than one result, so a non-last result is a fired one.
	a_non_last_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == ST_FIRED))
		else $error("non-last result that is not a fired timer");

	// A result started by a flush always carries the last mark.
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.flush |=> (m_tvalid && m_tlast))
		else $error("flushed result without last mark");

endmodule

/* tb/tb_timeout_table.sv */
// Self-checking testbench for the timeout table: drives add, remove and tick items into the
// stream input and compares every result against an in-bench copy of the timer table.
// Depends on tt_pkg and the timeout_table RTL only.
module tb_timeout_table import tt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_TIMERS = NUM_TIMERS_DEF;
	// The block ignores this command code.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One expected result: status, handle and the last-of-item mark.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic                last;
	} report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;   // now_ms[31:0], delay_ms[63:32], one_shot[64],
	                             // handle_in[80:65], zeros[87:81]
	logic [1:0]  s_tuser = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // handle_out[15:0]
	logic [2:0]  m_tuser;        // status[2:0]
	logic        m_tlast;

	// Shadow copy of the timer table, kept packed in insertion order.
	logic [HANDLE_W-1:0] tbl_handle [NUM_TIMERS];
	logic [31:0]         tbl_start  [NUM_TIMERS];
	logic [31:0]         tbl_delay  [NUM_TIMERS];
	logic                tbl_shot   [NUM_TIMERS];
	int                  tbl_count = 0;
	logic [HANDLE_W-1:0] next_hdl = '0;

	report_t     awaited_reports[$];
	int          mismatch_count = 0;
	int          snd_idle_pct = 0;
	int          rcv_idle_pct = 0;
	logic [31:0] wall_ms = '0;

	timeout_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Clock with a 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin
		repeat (5_000_000) @(posedge clk);
		$display("status: fail");
		$finish;
	end

	// Prints one line per mismatch and counts it.
	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Removes one entry and closes the gap behind it.
	function automatic void drop_entry(input int idx);
		int k;
		for (k = idx; k + 1 < tbl_count; k++) begin
			tbl_handle[k] = tbl_handle[k + 1];
			tbl_start[k]  = tbl_start[k + 1];
			tbl_delay[k]  = tbl_delay[k + 1];
			tbl_shot[k]   = tbl_shot[k + 1];
		end
		tbl_count--;
	endfunction

	// Applies one accepted item to the shadow table and queues the results it causes.
	function automatic void table_step(input logic [1:0] op, input logic [31:0] now,
			input logic [31:0] dly, input logic shot, input logic [15:0] hin);
		report_t     batch[$];
		report_t     r;
		logic [31:0] elapsed;
		int          i;
		int          hit;
		case (op)
			CMD_TICK: begin
				// Fire in table order; a fired one-shot goes, so the same index is looked at again.
				i = 0;
				while (i < tbl_count) begin
					elapsed = now - tbl_start[i];
					if (elapsed > tbl_delay[i]) begin
						batch.insert(batch.size(), {ST_FIRED, tbl_handle[i], 1'b0});
						if (tbl_shot[i]) begin
							drop_entry(i);
						end else begin
							tbl_start[i] = now;
							i++;
						end
					end else begin
						i++;
					end
				end
			end
			CMD_ADD: begin
				if (tbl_count >= NUM_TIMERS) begin
					batch.insert(batch.size(), {ST_FULL, 16'h0000, 1'b0});
				end else begin
					tbl_handle[tbl_count] = next_hdl;
					tbl_start[tbl_count]  = now;
					tbl_delay[tbl_count]  = dly;
					tbl_shot[tbl_count]   = shot;
					tbl_count++;
					batch.insert(batch.size(), {ST_ADDED, next_hdl, 1'b0});
					next_hdl = next_hdl + 16'd1;
				end
			end
			CMD_REMOVE: begin
				// The earliest entry with a matching handle is the one removed.
				hit = -1;
				for (i = 0; i < tbl_count && hit < 0; i++)
					if (tbl_handle[i] == hin)
						hit = i;
				if (hit >= 0) begin
					drop_entry(hit);
					batch.insert(batch.size(), {ST_REMOVED, hin, 1'b0});
				end else begin
					batch.insert(batch.size(), {ST_NOTFOUND, hin, 1'b0});
				end
			end
			default: begin
			end
		endcase
		foreach (batch[k]) begin
			r = batch[k];
			r.last = (k == batch.size() - 1);
			awaited_reports.insert(awaited_reports.size(), r);
		end
	endfunction

	// Presents one item at the falling edge, after a random gap, and holds it until accepted.
	task automatic send_item(input logic [1:0] op, input logic [31:0] now,
			input logic [31:0] dly, input logic shot, input logic [15:0] hin);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, hin, shot, dly, now};
		do
			@(posedge clk);
		while (!s_tready);
		table_step(op, now, dly, shot, hin);
	endtask

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);

	// Every accepted result is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_reports.size() == 0) begin
				flag_mismatch($sformatf("unexpected result status %0d handle %h last %b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = awaited_reports.pop_front();
				if (m_tuser !== want.status)
					flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
				if (m_tdata !== want.handle)
					flag_mismatch($sformatf("handle %h, expected %h", m_tdata, want.handle));
				if (m_tlast !== want.last)
					flag_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
			end
		end
	end

	// Fills the table with extreme and mixed delays, then adds one more for a full report.
	task automatic test_fill_table();
		logic [31:0] dly;
		wall_ms = 32'hFFFF_FFF0;
		for (int k = 0; k < NUM_TIMERS; k++) begin
			dly = (k == 1) ? 32'hFFFF_FFFF : 32'(2 * k);
			send_item(CMD_ADD, wall_ms, dly, k[0], 16'hFFFF);
		end
		send_item(CMD_ADD, wall_ms, 32'd3, 1'b1, 16'h0000);
	endtask

	// Ticks with nothing due, across the time wrap, and at exactly the delay.
	task automatic test_tick_rules();
		send_item(CMD_TICK, wall_ms, 32'h0, 1'b0, 16'h0);
		wall_ms = wall_ms + 32'h20;
		send_item(CMD_TICK, wall_ms, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		send_item(CMD_TICK, wall_ms + 32'd4, 32'h0, 1'b0, 16'h0);
		wall_ms = wall_ms + 32'd5;
		send_item(CMD_TICK, wall_ms, 32'h0, 1'b0, 16'h0);
	endtask

	// Removes a middle entry, then asks for handles that are not there, then the unused code.
	task automatic test_remove_rules();
		logic [15:0] hnd;
		hnd = tbl_handle[tbl_count / 2];
		send_item(CMD_REMOVE, 32'h0, 32'h0, 1'b0, hnd);
		send_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, hnd);
		send_item(CMD_REMOVE, 32'h0, 32'h0, 1'b0, 16'hFFFF);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
	endtask

	// Empties the table and refills it, then checks that a remove in the middle keeps the
	// order of the rest and that zero-delay one-shots fire and go on the next tick.
	task automatic test_refill();
		while (tbl_count > 0)
			send_item(CMD_REMOVE, 32'h0, 32'h0, 1'b0, tbl_handle[0]);
		send_item(CMD_ADD, wall_ms, 32'd10, 1'b0, 16'h0);
		send_item(CMD_ADD, wall_ms, 32'd50, 1'b0, 16'h0);
		send_item(CMD_ADD, wall_ms, 32'd0, 1'b1, 16'h0);
		send_item(CMD_ADD, wall_ms, 32'd0, 1'b1, 16'h0);
		send_item(CMD_REMOVE, wall_ms, 32'h0, 1'b0, tbl_handle[1]);
		send_item(CMD_TICK, wall_ms + 32'd1, 32'h0, 1'b0, 16'h0);
		wall_ms = wall_ms + 32'd5;
		send_item(CMD_TICK, wall_ms, 32'h0, 1'b0, 16'h0);
	endtask

	// Random traffic: mostly well-formed adds, ticks and removes of live handles, some noise.
	task automatic run_traffic(input int n_items);
		int          done_items;
		int          pick;
		logic [31:0] dly;
		logic [15:0] hnd;
		done_items = 0;
		while (done_items < n_items) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				dly = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
				if ($urandom_range(19) == 0)
					wall_ms = $urandom;
				send_item(CMD_ADD, wall_ms, dly, 1'($urandom_range(1)), 16'($urandom));
				done_items++;
			end else if (pick < 75) begin
				wall_ms = ($urandom_range(24) == 0) ? $urandom : wall_ms + $urandom_range(30);
				send_item(CMD_TICK, wall_ms, $urandom, 1'($urandom_range(1)), 16'($urandom));
				done_items++;
			end else if (pick < 95) begin
				if (tbl_count > 0 && $urandom_range(4) != 0)
					hnd = tbl_handle[$urandom_range(tbl_count - 1)];
				else
					hnd = 16'($urandom);
				send_item(CMD_REMOVE, $urandom, $urandom, 1'($urandom_range(1)), hnd);
				done_items++;
			end else begin
				// Ignored by the block, so it does not count as traffic.
				send_item(CMD_UNUSED, $urandom, $urandom, 1'($urandom_range(1)),
					16'($urandom));
			end
		end
	endtask

	// Test sequence.
	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		snd_idle_pct = 13;
		rcv_idle_pct = 55;
		test_fill_table();
		test_tick_rules();
		test_remove_rules();
		test_refill();
		run_traffic(35);

		snd_idle_pct = 55;
		rcv_idle_pct = 13;
		wall_ms = 32'hFFFF_FFC0;
		run_traffic(35);

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		run_traffic(35);

		// Drain: wait for every expected result, then give the block time to show extras.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_reports.size() != 0)
			@(posedge clk);
		repeat (NUM_TIMERS + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
